/* hw/rtl/mcinv_pkg.sv */
// Package with the types, constants and index functions of the 4x4 cofactor inverse unit.
`timescale 1ns / 1ps
package mcinv_pkg;

    // Datapath widths.
    localparam int W_ELEM = 32;
    localparam int W_THR  = 31;
    localparam int W_OPND = 33;
    localparam int W_PROD = 66;
    localparam int W_PAIR = 64;
    localparam int W_COF  = 97;
    localparam int W_ACC  = 132;
    localparam int W_DSH  = 166;
    localparam int W_QUO  = 34;

    // Division runs one quotient bit a cycle, from bit 33 down to bit 0.
    localparam logic [5:0] DIV_LAST_STEP = 6'd33;

    // Fixed result codes.
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // Controller states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_COF,
        S_COF_WR,
        S_DET,
        S_DMAG,
        S_CHECK,
        S_DIV_INIT,
        S_DIV_ADD,
        S_DIV_STEP,
        S_EMIT
    } t_state;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_EE,
        MUL_PL,
        MUL_PH,
        MUL_C0,
        MUL_C1,
        MUL_C2
    } t_mul_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       elem_wr;
        logic [3:0] elem_idx;
        logic       mul_en;
        t_mul_sel   mul_sel;
        logic [3:0] idx_a;
        logic [3:0] idx_b;
        logic       p_load;
        logic       acc_clr;
        logic       acc_en;
        logic [1:0] acc_shift;
        logic       acc_neg;
        logic       cof_wr;
        logic [3:0] cof_idx;
        logic       det_latch;
        logic       div_init;
        logic       div_add;
        logic       div_step;
        logic       out_load;
        logic [3:0] out_idx;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sing;
        logic out_busy;
    } t_dp_stat;

    // Store index of minor slot (si, sj) for inverse position k = 4c + r.
    function automatic logic [3:0] elem_index(input logic [3:0] k, input logic [1:0] si,
                                              input logic [1:0] sj);
        logic [1:0] i_row;
        logic [1:0] j_col;
        i_row = si + {1'b0, (si >= k[3:2])};
        j_col = sj + {1'b0, (sj >= k[1:0])};
        return {j_col, i_row};
    endfunction

    // Minor columns of the three factors of term t, as {a, b, c}.
    function automatic logic [5:0] term_cols(input logic [2:0] t);
        logic [5:0] cols;
        case (t)
            3'd0:    cols = {2'd0, 2'd1, 2'd2};
            3'd1:    cols = {2'd0, 2'd2, 2'd1};
            3'd2:    cols = {2'd1, 2'd0, 2'd2};
            3'd3:    cols = {2'd1, 2'd2, 2'd0};
            3'd4:    cols = {2'd2, 2'd0, 2'd1};
            3'd5:    cols = {2'd2, 2'd1, 2'd0};
            default: cols = 6'd0;
        endcase
        return cols;
    endfunction

    // Terms of odd permutation enter the minor negated.
    function automatic logic term_neg(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

/* hw/rtl/mcinv_ifs.sv */
// Channel interfaces of the 4x4 cofactor inverse unit.
`timescale 1ns / 1ps

// Element input channel.
interface mcinv_elem_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element_value;
    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// Result output channel.
interface mcinv_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic        [3:0]  result_index;
    logic               last_element;
    logic               singular;
    logic               clipped;
    modport source (output valid, output result_value, output result_index,
                    output last_element, output singular, output clipped, input ready);
    modport sink   (input valid, input result_value, input result_index,
                    input last_element, input singular, input clipped, output ready);
endinterface

// Threshold write channel.
interface mcinv_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] singular_threshold;
    modport source (output valid, output singular_threshold, input ready);
    modport sink   (input valid, input singular_threshold, output ready);
endinterface

/* hw/rtl/mcinv_ctrl.sv */
// Controller state machine that sequences loading, cofactors, determinant, division and output.
`timescale 1ns / 1ps
module mcinv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mcinv_pkg::t_dp_stat i_stat,
    output mcinv_pkg::t_dp_cmd  o_cmd
);
    import mcinv_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_load_cnt, n_load_cnt;
    logic [3:0] r_k, n_k;
    logic [2:0] r_t, n_t;
    logic [2:0] r_ph, n_ph;
    logic [5:0] r_bit, n_bit;
    logic [5:0] cols;
    logic       cof_sign;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= 4'd0;
            r_k        <= 4'd0;
            r_t        <= 3'd0;
            r_ph       <= 3'd0;
            r_bit      <= 6'd0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_k        <= n_k;
            r_t        <= n_t;
            r_ph       <= n_ph;
            r_bit      <= n_bit;
        end
    end

    assign cols     = term_cols(r_t);
    assign cof_sign = term_neg(r_t) ^ r_k[0] ^ r_k[2];
    assign o_in_ready = (r_state == S_LOAD);

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_k        = r_k;
        n_t        = r_t;
        n_ph       = r_ph;
        n_bit      = r_bit;
        o_cmd      = '0;
        o_cmd.mul_sel  = MUL_EE;
        o_cmd.elem_idx = r_load_cnt;
        o_cmd.cof_idx  = r_k;
        o_cmd.out_idx  = r_k;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.elem_wr = 1'b1;
                    n_load_cnt    = r_load_cnt + 4'd1;
                    if (r_load_cnt == 4'd15) begin
                        o_cmd.acc_clr = 1'b1;
                        n_k     = 4'd0;
                        n_t     = 3'd0;
                        n_ph    = 3'd0;
                        n_state = S_COF;
                    end
                end
            end
            S_COF: begin
                // Six phases per triple product: pair product, then two limb products.
                n_ph = r_ph + 3'd1;
                case (r_ph)
                    3'd0: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_EE;
                        o_cmd.idx_a   = elem_index(r_k, 2'd0, cols[5:4]);
                        o_cmd.idx_b   = elem_index(r_k, 2'd1, cols[3:2]);
                    end
                    3'd1: o_cmd.p_load = 1'b1;
                    3'd2: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_PL;
                        o_cmd.idx_b   = elem_index(r_k, 2'd2, cols[1:0]);
                    end
                    3'd3: begin
                        o_cmd.acc_en    = 1'b1;
                        o_cmd.acc_shift = 2'd0;
                        o_cmd.acc_neg   = cof_sign;
                    end
                    3'd4: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_PH;
                        o_cmd.idx_b   = elem_index(r_k, 2'd2, cols[1:0]);
                    end
                    default: begin
                        o_cmd.acc_en    = 1'b1;
                        o_cmd.acc_shift = 2'd1;
                        o_cmd.acc_neg   = cof_sign;
                        n_ph = 3'd0;
                        if (r_t == 3'd5) begin
                            n_t     = 3'd0;
                            n_state = S_COF_WR;
                        end else begin
                            n_t = r_t + 3'd1;
                        end
                    end
                endcase
            end
            S_COF_WR: begin
                o_cmd.cof_wr  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                if (r_k == 4'd15) begin
                    n_k     = 4'd0;
                    n_state = S_DET;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = S_COF;
                end
            end
            S_DET: begin
                // First-column expansion, one cofactor limb per multiply.
                o_cmd.cof_idx = {r_k[1:0], 2'b00};
                o_cmd.idx_b   = {2'b00, r_k[1:0]};
                if (r_ph == 3'd0) begin
                    o_cmd.mul_en = 1'b1;
                    case (r_t)
                        3'd0:    o_cmd.mul_sel = MUL_C0;
                        3'd1:    o_cmd.mul_sel = MUL_C1;
                        default: o_cmd.mul_sel = MUL_C2;
                    endcase
                    n_ph = 3'd1;
                end else begin
                    o_cmd.acc_en    = 1'b1;
                    o_cmd.acc_shift = r_t[1:0];
                    n_ph = 3'd0;
                    if (r_t == 3'd2) begin
                        n_t = 3'd0;
                        if (r_k == 4'd3) begin
                            n_k     = 4'd0;
                            n_state = S_DMAG;
                        end else begin
                            n_k = r_k + 4'd1;
                        end
                    end else begin
                        n_t = r_t + 3'd1;
                    end
                end
            end
            S_DMAG: begin
                o_cmd.det_latch = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.sing ? S_EMIT : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV_ADD;
            end
            S_DIV_ADD: begin
                o_cmd.div_add = 1'b1;
                n_bit   = 6'd0;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                n_bit = r_bit + 6'd1;
                if (r_bit == DIV_LAST_STEP) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    if (r_k == 4'd15) begin
                        n_k     = 4'd0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = i_stat.sing ? S_EMIT : S_DIV_INIT;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

/* hw/rtl/mcinv_dp.sv */
// Datapath: element store, shared multiplier, wide accumulator, divider and output register.
`timescale 1ns / 1ps
module mcinv_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcinv_pkg::t_dp_cmd  i_cmd,
    output mcinv_pkg::t_dp_stat o_stat,
    input  logic signed [31:0]  i_element_value,
    input  logic                i_cfg_valid,
    input  logic [30:0]         i_cfg_threshold,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [31:0]  o_result_value,
    output logic [3:0]          o_result_index,
    output logic                o_last_element,
    output logic                o_singular,
    output logic                o_clipped
);
    import mcinv_pkg::*;

    logic [W_ELEM-1:0]        r_elem [16];
    logic [W_COF-1:0]         r_cof  [16];
    logic [W_THR-1:0]         r_thr;
    logic signed [W_PROD-1:0] r_mul;
    logic [W_PAIR-1:0]        r_p;
    logic [W_ACC-1:0]         r_acc;
    logic [W_ACC-1:0]         r_dmag;
    logic                     r_dneg;
    logic [W_ACC-1:0]         r_rem;
    logic [W_DSH-1:0]         r_dsh;
    logic [W_QUO-1:0]         r_q;
    logic                     r_qneg;
    logic                     r_out_valid;

    logic signed [W_OPND-1:0] op_a, op_b;
    logic [W_ELEM-1:0]        elem_a, elem_b;
    logic [W_COF-1:0]         cof_rd;
    logic [W_ACC-1:0]         prod_ext, addend;
    logic [W_COF-1:0]         cof_mag;
    logic [W_DSH-1:0]         rem_ext;
    logic                     sing;
    logic [31:0]              res_val;
    logic                     res_clip;

    assign elem_a = r_elem[i_cmd.idx_a];
    assign elem_b = r_elem[i_cmd.idx_b];
    assign cof_rd = r_cof[i_cmd.cof_idx];

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 31'd1;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_threshold;
        end
    end

    // Element and cofactor stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.elem_wr) begin
            r_elem[i_cmd.elem_idx] <= i_element_value;
        end
        if (i_cmd.cof_wr) begin
            r_cof[i_cmd.cof_idx] <= r_acc[W_COF-1:0];
        end
    end

    // Operand selection for the shared 33x33 signed multiplier.
    always_comb begin
        op_b = {elem_b[W_ELEM-1], elem_b};
        case (i_cmd.mul_sel)
            MUL_EE:  op_a = {elem_a[W_ELEM-1], elem_a};
            MUL_PL:  op_a = {1'b0, r_p[31:0]};
            MUL_PH:  op_a = {r_p[63], r_p[63:32]};
            MUL_C0:  op_a = {1'b0, cof_rd[31:0]};
            MUL_C1:  op_a = {1'b0, cof_rd[63:32]};
            MUL_C2:  op_a = cof_rd[96:64];
            default: op_a = '0;
        endcase
    end

    // Multiplier and pair product registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mul <= op_a * op_b;
        end
        if (i_cmd.p_load) begin
            r_p <= r_mul[W_PAIR-1:0];
        end
    end

    // Limb-aligned addend for the accumulator.
    always_comb begin
        prod_ext = {{(W_ACC - W_PROD){r_mul[W_PROD-1]}}, r_mul};
        case (i_cmd.acc_shift)
            2'd0:    addend = prod_ext;
            2'd1:    addend = {prod_ext[W_ACC-33:0], 32'd0};
            default: addend = {prod_ext[W_ACC-65:0], 64'd0};
        endcase
    end

    // Accumulator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_neg ? (r_acc - addend) : (r_acc + addend);
        end
    end

    // Determinant magnitude and singularity test against the threshold in Q64.64.
    always_ff @(posedge i_clk) begin
        if (i_cmd.det_latch) begin
            r_dneg <= r_acc[W_ACC-1];
            r_dmag <= r_acc[W_ACC-1] ? (W_ACC'(0) - r_acc) : r_acc;
        end
    end

    assign sing = (r_dmag <= {53'd0, r_thr, 48'd0});

    // Restoring division of 2|C|*2^32 + |D| by 2|D|, one quotient bit a cycle.
    assign cof_mag = cof_rd[W_COF-1] ? (W_COF'(0) - cof_rd) : cof_rd;
    assign rem_ext = {{(W_DSH - W_ACC){1'b0}}, r_rem};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= {2'b00, cof_mag, 33'd0};
            r_dsh  <= {r_dmag, 34'd0};
            r_q    <= '0;
            r_qneg <= cof_rd[W_COF-1] ^ r_dneg;
        end else if (i_cmd.div_add) begin
            r_rem <= r_rem + r_dmag;
        end else if (i_cmd.div_step) begin
            if (rem_ext >= r_dsh) begin
                r_rem <= r_rem - r_dsh[W_ACC-1:0];
                r_q   <= {r_q[W_QUO-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[W_QUO-2:0], 1'b0};
            end
            r_dsh <= {1'b0, r_dsh[W_DSH-1:1]};
        end
    end

    // Result value with saturation, or the identity for a singular matrix.
    always_comb begin
        res_clip = 1'b0;
        if (sing) begin
            res_val = (i_cmd.out_idx[1:0] == i_cmd.out_idx[3:2]) ? ONE_Q16 : 32'd0;
        end else if (!r_qneg) begin
            if (r_q[33] || r_q[32] || r_q[31]) begin
                res_val  = SAT_POS;
                res_clip = 1'b1;
            end else begin
                res_val = r_q[31:0];
            end
        end else begin
            if (r_q[33] || r_q[32] || (r_q[31] && (r_q[30:0] != 31'd0))) begin
                res_val  = SAT_NEG;
                res_clip = 1'b1;
            end else begin
                res_val = 32'd0 - r_q[31:0];
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result_value <= res_val;
            o_result_index <= i_cmd.out_idx;
            o_last_element <= (i_cmd.out_idx == 4'd15);
            o_singular     <= sing;
            o_clipped      <= res_clip;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.sing     = sing;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

endmodule

/* hw/rtl/matrix4_cofactor_inverse_unit.sv */
// Top level of the 4x4 cofactor matrix inverse unit, signed Q16.16.
//
//   Channel   Direction  Payload                                          Transfer
//   i_elem    in         element_value, column-major                      valid & ready
//   o_res     out        result_value, result_index, last_element,        valid & ready
//                        singular, clipped
//   i_cfg     in         singular_threshold (unsigned Q15.16)             valid & ready
//
// The sixteenth element transfer starts the computation. Each cofactor is summed from six
// triple products on the one shared multiplier; the determinant follows, then its
// magnitude and the singularity test. Each nonsingular result is then formed in the
// bit-serial divider (34 quotient bits); singular results go straight to the output.
// Reset is synchronous, active low; a stalled result holds the pipeline in place.
`timescale 1ns / 1ps
module matrix4_cofactor_inverse_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcinv_elem_if.sink      i_elem,
    mcinv_res_if.source     o_res,
    mcinv_cfg_if.sink       i_cfg
);
    import mcinv_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Threshold writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Sequencer.
    mcinv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_elem.valid),
        .o_in_ready (i_elem.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    mcinv_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_element_value (i_elem.element_value),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_threshold (i_cfg.singular_threshold),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_result_value  (o_res.result_value),
        .o_result_index  (o_res.result_index),
        .o_last_element  (o_res.last_element),
        .o_singular      (o_res.singular),
        .o_clipped       (o_res.clipped)
    );

endmodule

/* hw/rtl/mcinv_chk.sv */
// Port-level assertion checker for the 4x4 cofactor inverse unit, with its bind.
`timescale 1ns / 1ps
module mcinv_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_result_value,
    input logic [3:0]  i_result_index,
    input logic        i_last_element,
    input logic        i_singular,
    input logic        i_clipped
);

    // A stalled result stays offered with the same value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_value))
        else $error("stalled result changed");

    // The last flag marks exactly index fifteen.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_element == (i_result_index == 4'd15)))
        else $error("last flag does not match index");

    // An identity result is never flagged as saturated.
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_singular |-> !i_clipped)
        else $error("singular result flagged clipped");

    // No new element is taken while a run still has results to deliver.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_element |-> !i_in_ready)
        else $error("input ready during result delivery");

endmodule

bind matrix4_cofactor_inverse_unit mcinv_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_elem.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_result_value (o_res.result_value),
    .i_result_index (o_res.result_index),
    .i_last_element (o_res.last_element),
    .i_singular     (o_res.singular),
    .i_clipped      (o_res.clipped)
);

/* sim/matrix4_cofactor_inverse_unit_checker.sv */
// Checker for the 4x4 cofactor inverse unit: predicts each inverse and compares the results.
`timescale 1ns / 1ps
module matrix4_cofactor_inverse_unit_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mcinv_elem_if  elem_ch,
    mcinv_res_if   res_ch,
    mcinv_cfg_if   cfg_ch,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_result_count,
    output int     o_singular_count,
    output int     o_clipped_count
);
    import mcinv_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic [3:0]         index;
        logic               last;
        logic               singular;
        logic               clipped;
    } t_inv_elem;

    logic signed [31:0] matrix_q [16];
    logic [3:0]         fill_count;
    logic [30:0]        threshold_q;
    t_inv_elem          inverse_q [$];

    // Signed cofactor for inverse position k = 4c + r, exact in wide integers.
    function automatic logic signed [191:0] cofactor_of(input int k);
        logic signed [191:0] e [9];
        logic signed [191:0] m1, m2, m3, d;
        int r, c, n;
        r = k % 4;
        c = k / 4;
        n = 0;
        for (int i = 0; i < 4; i++) begin
            if (i != c) begin
                for (int j = 0; j < 4; j++) begin
                    if (j != r) begin
                        e[n] = matrix_q[j * 4 + i];
                        n++;
                    end
                end
            end
        end
        m1 = e[4] * e[8] - e[5] * e[7];
        m2 = e[3] * e[8] - e[5] * e[6];
        m3 = e[3] * e[7] - e[4] * e[6];
        d  = e[0] * m1 - e[1] * m2 + e[2] * m3;
        return ((r + c) % 2 == 1) ? -d : d;
    endfunction

    // Form the 16 expected results of the loaded matrix.
    task automatic predict_inverse();
        logic signed [191:0] cof [16];
        logic signed [191:0] det;
        logic [191:0]        dmag, cmag, lim, quo;
        logic                sing, neg;
        t_inv_elem           r;
        det = '0;
        for (int k = 0; k < 16; k++) cof[k] = cofactor_of(k);
        for (int k = 0; k < 4; k++) begin
            det = det + cof[k * 4] * 192'(matrix_q[k]);
        end
        dmag = (det < 0) ? -det : det;
        lim  = 192'(threshold_q) << 48;
        sing = (dmag <= lim);
        for (int k = 0; k < 16; k++) begin
            r.index    = k[3:0];
            r.last     = (k == 15);
            r.singular = sing;
            r.clipped  = 1'b0;
            if (sing) begin
                r.value = (k % 5 == 0) ? ONE_Q16 : 32'd0;
            end else begin
                neg  = (cof[k] < 0) != (det < 0);
                cmag = (cof[k] < 0) ? -cof[k] : cof[k];
                // Round to nearest, ties away from zero.
                quo  = ((cmag << 33) + dmag) / (dmag << 1);
                if (!neg) begin
                    if (quo > 192'h7FFF_FFFF) begin
                        r.value   = SAT_POS;
                        r.clipped = 1'b1;
                    end else begin
                        r.value = quo[31:0];
                    end
                end else begin
                    if (quo > 192'h8000_0000) begin
                        r.value   = SAT_NEG;
                        r.clipped = 1'b1;
                    end else begin
                        r.value = -quo[31:0];
                    end
                end
            end
            inverse_q.push_back(r);
        end
    endtask

    // Track every transfer on the three channels.
    always @(posedge i_clk) begin
        t_inv_elem x;
        if (!i_rst_n) begin
            fill_count       <= '0;
            threshold_q      <= 31'd1;
            o_fail_count     <= 0;
            o_result_count   <= 0;
            o_singular_count <= 0;
            o_clipped_count  <= 0;
            inverse_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                threshold_q <= cfg_ch.singular_threshold;
            end
            if (elem_ch.valid && elem_ch.ready) begin
                matrix_q[fill_count] = elem_ch.element_value;
                fill_count <= fill_count + 4'd1;
                if (fill_count == 4'd15) predict_inverse();
            end
            if (res_ch.valid && res_ch.ready) begin
                o_result_count <= o_result_count + 1;
                if (inverse_q.size() == 0) begin
                    $error("result transfer with no expected result, value %h",
                           res_ch.result_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    x = inverse_q.pop_front();
                    if (x.singular) o_singular_count <= o_singular_count + 1;
                    if (x.clipped) o_clipped_count <= o_clipped_count + 1;
                    if (res_ch.result_value !== x.value ||
                        res_ch.result_index !== x.index ||
                        res_ch.last_element !== x.last ||
                        res_ch.singular !== x.singular ||
                        res_ch.clipped !== x.clipped) begin
                        o_fail_count <= o_fail_count + 1;
                        if (res_ch.result_value !== x.value)
                            $error("result_value: expected %h, got %h", x.value,
                                   res_ch.result_value);
                        if (res_ch.result_index !== x.index)
                            $error("result_index: expected %0d, got %0d", x.index,
                                   res_ch.result_index);
                        if (res_ch.last_element !== x.last)
                            $error("last_element: expected %b, got %b", x.last,
                                   res_ch.last_element);
                        if (res_ch.singular !== x.singular)
                            $error("singular: expected %b, got %b", x.singular,
                                   res_ch.singular);
                        if (res_ch.clipped !== x.clipped)
                            $error("clipped: expected %b, got %b", x.clipped,
                                   res_ch.clipped);
                    end
                end
            end
        end
        o_pending <= inverse_q.size();
    end

endmodule

/* sim/matrix4_cofactor_inverse_unit_tb.sv */
// Testbench top of the 4x4 cofactor inverse unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module matrix4_cofactor_inverse_unit_tb;
    import mcinv_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int MATS_PER_PHASE = 4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, result_count, singular_count, clipped_count;
    int   quiet_cycles = 0;
    int   matrix_count = 0;
    bit   hold_request = 1'b0;
    bit   send_calm = 1'b0;
    bit   recv_calm = 1'b0;

    mcinv_elem_if elem_ch ();
    mcinv_res_if  res_ch ();
    mcinv_cfg_if  cfg_ch ();

    matrix4_cofactor_inverse_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    matrix4_cofactor_inverse_unit_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .elem_ch          (elem_ch),
        .res_ch           (res_ch),
        .cfg_ch           (cfg_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_singular_count (singular_count),
        .o_clipped_count  (clipped_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** matrix4_cofactor_inverse_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, calm stretches and one long hold-off.
    initial begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) recv_calm = ~recv_calm;
            gap = recv_calm ? 0 : $urandom_range(0, 11);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Send one element, then draw the gap before the next one.
    task automatic send_element(input logic [31:0] v);
        int gap;
        elem_ch.valid <= 1'b1;
        elem_ch.element_value <= v;
        do @(posedge i_clk); while (!elem_ch.ready);
        if ($urandom_range(0, 15) == 0) send_calm = ~send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_matrix(input logic [31:0] m [16]);
        for (int k = 0; k < 16; k++) send_element(m[k]);
        matrix_count++;
    endtask

    // Threshold write once the unit has drained.
    task automatic write_threshold(input logic [30:0] thr);
        elem_ch.valid <= 1'b0;
        // Let the count of expected results catch up with the last element transfer.
        @(posedge i_clk);
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.singular_threshold <= thr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] small_value();
        return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Random matrix of one of several shapes.
    task automatic random_matrix(output logic [31:0] m [16]);
        int shape;
        shape = $urandom_range(0, 9);
        for (int k = 0; k < 16; k++) begin
            case (shape)
                6:       m[k] = $urandom();
                8:       m[k] = edge_value();
                9:       m[k] = (k % 5 == 0) ? 32'($urandom_range(1, 40))
                                             : 32'($signed($urandom_range(0, 8)) - 4);
                default: m[k] = small_value();
            endcase
        end
        // Repeated column gives a zero determinant.
        if (shape == 7) begin
            for (int k = 0; k < 4; k++) m[12 + k] = m[k];
        end
    endtask

    initial begin
        logic [31:0] mat [16];
        logic [30:0] thr_list [5];
        elem_ch.valid = 1'b0;
        elem_ch.element_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.singular_threshold = '0;
        thr_list[0] = 31'd1;
        thr_list[1] = 31'd0;
        thr_list[2] = 31'h7FFF_FFFF;
        thr_list[3] = 31'h0001_0000;
        thr_list[4] = 31'($urandom());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Diagonal with extreme values: the tiny entry makes its inverse clip.
        for (int k = 0; k < 16; k++) mat[k] = 32'd0;
        mat[0] = 32'h0000_0001;
        mat[5] = 32'h7FFF_FFFF;
        mat[10] = 32'h8000_0000;
        mat[15] = ONE_Q16;
        send_matrix(mat);
        // Rank one matrix of the most negative value is singular.
        for (int k = 0; k < 16; k++) mat[k] = 32'h8000_0000;
        send_matrix(mat);

        for (int p = 0; p < 5; p++) begin
            if (p > 0) write_threshold(thr_list[p]);
            for (int n = 0; n < MATS_PER_PHASE; n++) begin
                if (p == 1 && n == 1) hold_request = 1'b1;
                random_matrix(mat);
                send_matrix(mat);
            end
        end
        elem_ch.valid <= 1'b0;

        // Let the count of expected results catch up with the last element transfer.
        @(posedge i_clk);
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d matrices and %0d results over five threshold settings,",
                 matrix_count, result_count);
        $display("with %0d singular and %0d saturated results.", singular_count,
                 clipped_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** matrix4_cofactor_inverse_unit: PASSED **");
        end else begin
            $display("** matrix4_cofactor_inverse_unit: FAILED **");
        end
        $finish;
    end

endmodule
